[rtl/core/brfr_pkg.sv]
// ----------------------------------------------------------------------------
// brfr_pkg
// Shared types, codes and helpers of the boot reply frame receiver.
// ----------------------------------------------------------------------------
package brfr_pkg;

    localparam int unsigned CodeWidth    = 4;
    localparam int unsigned KindWidth    = 3;
    localparam int unsigned SeqWidth     = 4;
    localparam int unsigned PayloadWidth = 16;
    localparam int unsigned ByteWidth    = 8;
    localparam int unsigned CfgIdxWidth  = 2;
    localparam int unsigned OutDataWidth = 24;

    typedef logic [KindWidth-1:0] kind_t;

    localparam kind_t KIND_BOOT    = 3'd0;
    localparam kind_t KIND_ACK     = 3'd1;
    localparam kind_t KIND_CRCERR  = 3'd2;
    localparam kind_t KIND_BADSUM  = 3'd3;
    localparam kind_t KIND_UNKNOWN = 3'd4;

    typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_BOOT_ENTERED = 2'd0;
    localparam cfg_idx_t CFG_ACK          = 2'd1;
    localparam cfg_idx_t CFG_CRC_ERROR    = 2'd2;

    localparam logic [CodeWidth-1:0] BOOT_CODE_RST   = 4'd2;
    localparam logic [CodeWidth-1:0] ACK_CODE_RST    = 4'd3;
    localparam logic [CodeWidth-1:0] CRCERR_CODE_RST = 4'd4;

    typedef enum logic [3:0] {
        PH_ADDR = 4'b0001,
        PH_TYPE = 4'b0010,
        PH_DATA = 4'b0100,
        PH_SUM  = 4'b1000
    } phase_t;

    function automatic kind_t decode_kind(
        input logic [CodeWidth-1:0] frame_type,
        input logic [CodeWidth-1:0] boot_code,
        input logic [CodeWidth-1:0] ack_code,
        input logic [CodeWidth-1:0] crc_code
    );
        kind_t kind;
        if (frame_type == boot_code) begin
            kind = KIND_BOOT;
        end else if (frame_type == ack_code) begin
            kind = KIND_ACK;
        end else if (frame_type == crc_code) begin
            kind = KIND_CRCERR;
        end else begin
            kind = KIND_UNKNOWN;
        end
        return kind;
    endfunction

endpackage

[rtl/core/boot_reply_frame_receiver_unit.sv]
// ----------------------------------------------------------------------------
// boot_reply_frame_receiver_unit
// Deframes bootloader reply frames from a stream of received serial bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one received byte per beat in s_tdata[7:0]. Frames are
//   address, type/sequence, 0..2 payload bytes, checksum.
//   m_ channel: one beat per frame, at the checksum byte (or at the type byte
//   when the type matches no code): kind, sequence and payload.
//   cfg_ port: writes the three type code registers (index 0 boot entered,
//   1 acknowledge, 2 crc error); write only while the block is idle.
// Timing:
//   a byte accepted sits in the input register, and its result (if any)
//   moves from there into the output register once that register is free.
//   One byte per cycle is sustained while m_tready is high; the only loop
//   is the per-byte frame state update.
// Reset and stall:
//   aresetn (synchronous, low) empties both registers, restores the code
//   defaults and starts waiting for an address byte. When m_tready is low
//   with a result held, one more byte may wait in the input register, then
//   s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module boot_reply_frame_receiver_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // fields: rx_byte[7:0]
    input  logic [brfr_pkg::ByteWidth-1:0]   s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // fields: reply_kind[2:0], reply_seq[6:3], reply_payload[22:7], zero[23]
    output logic [brfr_pkg::OutDataWidth-1:0] m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_we,
    input  logic [brfr_pkg::CfgIdxWidth-1:0] cfg_index,
    input  logic [brfr_pkg::CodeWidth-1:0]   cfg_data
);

    logic [brfr_pkg::CodeWidth-1:0] boot_code_reg, ack_code_reg, crc_code_reg;

    logic                             in_valid_reg;
    logic [brfr_pkg::ByteWidth-1:0]   in_byte_reg;

    brfr_pkg::phase_t                 phase_reg, phase_next;
    logic [1:0]                       left_reg, left_next;
    logic [brfr_pkg::ByteWidth-1:0]   sum_reg, sum_next;
    logic [brfr_pkg::CodeWidth-1:0]   type_reg, type_next;
    logic [brfr_pkg::SeqWidth-1:0]    seq_reg, seq_next;
    logic [brfr_pkg::PayloadWidth-1:0] shift_reg, shift_next;

    logic                             out_valid_reg;
    brfr_pkg::kind_t                  kind_reg, kind_next;
    logic [brfr_pkg::SeqWidth-1:0]    oseq_reg, oseq_next;
    logic [brfr_pkg::PayloadWidth-1:0] opay_reg, opay_next;
    logic                             emit;

    logic                             out_free;
    logic                             advance;
    brfr_pkg::kind_t                  kind_dec;
    logic [brfr_pkg::ByteWidth-1:0]   sum_add;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign sum_add  = sum_reg + in_byte_reg;
    assign kind_dec = brfr_pkg::decode_kind(
        (phase_reg == brfr_pkg::PH_TYPE) ? in_byte_reg[3:0] : type_reg,
        boot_code_reg, ack_code_reg, crc_code_reg);

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        sum_next   = sum_add;
        type_next  = type_reg;
        seq_next   = seq_reg;
        shift_next = shift_reg;
        emit       = 1'b0;
        kind_next  = kind_dec;
        oseq_next  = seq_reg;
        opay_next  = '0;
        case (phase_reg)
            brfr_pkg::PH_ADDR: begin
                sum_next   = in_byte_reg;
                shift_next = '0;
                left_next  = 2'd0;
                phase_next = brfr_pkg::PH_TYPE;
            end
            brfr_pkg::PH_TYPE: begin
                type_next = in_byte_reg[3:0];
                seq_next  = in_byte_reg[7:4];
                oseq_next = in_byte_reg[7:4];
                case (kind_dec)
                    brfr_pkg::KIND_BOOT: begin
                        left_next  = 2'd2;
                        phase_next = brfr_pkg::PH_DATA;
                    end
                    brfr_pkg::KIND_CRCERR: begin
                        left_next  = 2'd1;
                        phase_next = brfr_pkg::PH_DATA;
                    end
                    brfr_pkg::KIND_ACK: begin
                        left_next  = 2'd0;
                        phase_next = brfr_pkg::PH_SUM;
                    end
                    default: begin
                        emit       = 1'b1;
                        phase_next = brfr_pkg::PH_ADDR;
                    end
                endcase
            end
            brfr_pkg::PH_DATA: begin
                shift_next = {shift_reg[brfr_pkg::PayloadWidth-brfr_pkg::ByteWidth-1:0],
                              in_byte_reg};
                left_next  = left_reg - 2'd1;
                if (left_reg == 2'd1) begin
                    phase_next = brfr_pkg::PH_SUM;
                end
            end
            default: begin
                emit       = 1'b1;
                phase_next = brfr_pkg::PH_ADDR;
                if (sum_add != '0) begin
                    kind_next = brfr_pkg::KIND_BADSUM;
                end else if (kind_dec == brfr_pkg::KIND_BOOT) begin
                    opay_next = shift_reg;
                end else if (kind_dec == brfr_pkg::KIND_CRCERR) begin
                    opay_next = {{(brfr_pkg::PayloadWidth-brfr_pkg::ByteWidth){1'b0}},
                                 shift_reg[brfr_pkg::ByteWidth-1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boot_code_reg <= brfr_pkg::BOOT_CODE_RST;
            ack_code_reg  <= brfr_pkg::ACK_CODE_RST;
            crc_code_reg  <= brfr_pkg::CRCERR_CODE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                brfr_pkg::CFG_BOOT_ENTERED: boot_code_reg <= cfg_data;
                brfr_pkg::CFG_ACK:          ack_code_reg  <= cfg_data;
                brfr_pkg::CFG_CRC_ERROR:    crc_code_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= brfr_pkg::PH_ADDR;
            left_reg  <= '0;
            sum_reg   <= '0;
            type_reg  <= '0;
            seq_reg   <= '0;
            shift_reg <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
            type_reg  <= type_next;
            seq_reg   <= seq_next;
            shift_reg <= shift_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && emit;
        end
        if (advance && emit) begin
            kind_reg <= kind_next;
            oseq_reg <= oseq_next;
            opay_reg <= opay_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, opay_reg, oseq_reg, kind_reg};

endmodule

[rtl/core/brfr_checker.sv]
// ----------------------------------------------------------------------------
// brfr_checker
// Port-level checks of the boot reply frame receiver, bound to boot_reply_frame_receiver_unit.
// ----------------------------------------------------------------------------
module brfr_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic [brfr_pkg::OutDataWidth-1:0] m_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready
);

    // held beat stays up
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // held beat keeps its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // kind in range and pad bit clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] == brfr_pkg::KIND_BOOT
                   || m_tdata[2:0] == brfr_pkg::KIND_ACK
                   || m_tdata[2:0] == brfr_pkg::KIND_CRCERR
                   || m_tdata[2:0] == brfr_pkg::KIND_BADSUM
                   || m_tdata[2:0] == brfr_pkg::KIND_UNKNOWN) && !m_tdata[23])
        else $error("bad reply kind");

    // kinds without payload and crc error carry a zero upper payload byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == brfr_pkg::KIND_ACK
                  || m_tdata[2:0] == brfr_pkg::KIND_BADSUM
                  || m_tdata[2:0] == brfr_pkg::KIND_UNKNOWN
                  || m_tdata[2:0] == brfr_pkg::KIND_CRCERR) |-> m_tdata[22:15] == '0)
        else $error("payload upper byte not zero");

    // no result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind boot_reply_frame_receiver_unit brfr_checker u_brfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives boot_reply_frame_receiver_unit with received bytes: a few directed
// frames first, then random frames mixed with stray bytes under several
// type code settings. Replies are predicted byte by byte and compared field
// by field. Both sides of the stream idle at random, and the result side
// also stalls for a long while.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 275;
    localparam int NUM_SETTINGS = 6;

    typedef struct packed {
        brfr_pkg::kind_t kind;
        logic [3:0]      seq;
        logic [15:0]     payload;
    } reply_t;

    class reply_scoreboard;
        logic [3:0]       boot_code;
        logic [3:0]       ack_code;
        logic [3:0]       crc_code;
        brfr_pkg::phase_t phase;
        logic [1:0]       bytes_left;
        logic [7:0]       sum;
        logic [3:0]       ftype;
        logic [3:0]       fseq;
        logic [15:0]      shift;
        reply_t           expected_q[$];
        int               errors;
        int               bytes_seen;
        int               replies_seen;

        function new();
            boot_code = brfr_pkg::BOOT_CODE_RST;
            ack_code = brfr_pkg::ACK_CODE_RST;
            crc_code = brfr_pkg::CRCERR_CODE_RST;
            phase = brfr_pkg::PH_ADDR;
            bytes_left = 0;
            sum = 0;
            ftype = 0;
            fseq = 0;
            shift = 0;
            errors = 0;
            bytes_seen = 0;
            replies_seen = 0;
        endfunction

        function void write_code(brfr_pkg::cfg_idx_t idx, logic [3:0] v);
            case (idx)
                brfr_pkg::CFG_BOOT_ENTERED: boot_code = v;
                brfr_pkg::CFG_ACK:          ack_code = v;
                brfr_pkg::CFG_CRC_ERROR:    crc_code = v;
                default: ;
            endcase
        endfunction

        function brfr_pkg::kind_t match_kind(logic [3:0] t);
            brfr_pkg::kind_t k;
            if (t == boot_code) k = brfr_pkg::KIND_BOOT;
            else if (t == ack_code) k = brfr_pkg::KIND_ACK;
            else if (t == crc_code) k = brfr_pkg::KIND_CRCERR;
            else k = brfr_pkg::KIND_UNKNOWN;
            return k;
        endfunction

        function void push_reply(brfr_pkg::kind_t k, logic [3:0] s, logic [15:0] pl);
            reply_t r;
            r.kind = k;
            r.seq = s;
            r.payload = pl;
            expected_q.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b);
            brfr_pkg::kind_t k;
            logic [7:0]      total;
            bytes_seen++;
            case (phase)
                brfr_pkg::PH_ADDR: begin
                    sum = b;
                    shift = 0;
                    bytes_left = 0;
                    phase = brfr_pkg::PH_TYPE;
                end
                brfr_pkg::PH_TYPE: begin
                    sum = sum + b;
                    ftype = b[3:0];
                    fseq = b[7:4];
                    k = match_kind(ftype);
                    if (k == brfr_pkg::KIND_UNKNOWN) begin
                        phase = brfr_pkg::PH_ADDR;
                        push_reply(brfr_pkg::KIND_UNKNOWN, fseq, 16'd0);
                    end else begin
                        bytes_left = (k == brfr_pkg::KIND_BOOT) ? 2'd2 :
                                     ((k == brfr_pkg::KIND_CRCERR) ? 2'd1 : 2'd0);
                        phase = (bytes_left != 0) ? brfr_pkg::PH_DATA : brfr_pkg::PH_SUM;
                    end
                end
                brfr_pkg::PH_DATA: begin
                    sum = sum + b;
                    shift = {shift[7:0], b};
                    bytes_left = bytes_left - 2'd1;
                    if (bytes_left == 0) phase = brfr_pkg::PH_SUM;
                end
                default: begin
                    phase = brfr_pkg::PH_ADDR;
                    total = sum + b;
                    if (total != 0) begin
                        push_reply(brfr_pkg::KIND_BADSUM, fseq, 16'd0);
                    end else begin
                        k = match_kind(ftype);
                        if (k == brfr_pkg::KIND_BOOT) push_reply(k, fseq, shift);
                        else if (k == brfr_pkg::KIND_CRCERR)
                            push_reply(k, fseq, {8'd0, shift[7:0]});
                        else push_reply(k, fseq, 16'd0);
                    end
                end
            endcase
        endfunction

        function void check_reply(logic [brfr_pkg::OutDataWidth-1:0] d);
            reply_t          exp;
            brfr_pkg::kind_t k;
            logic [3:0]      s;
            logic [15:0]     pl;
            k = d[2:0];
            s = d[6:3];
            pl = d[22:7];
            replies_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected reply: expected none, got kind %0d seq %0d payload %h",
                         $time, k, s, pl);
                return;
            end
            exp = expected_q.pop_front();
            if (k !== exp.kind) begin
                errors++;
                $display("%0t: kind mismatch: expected %0d, got %0d", $time, exp.kind, k);
            end
            if (s !== exp.seq) begin
                errors++;
                $display("%0t: seq mismatch: expected %0d, got %0d", $time, exp.seq, s);
            end
            if (pl !== exp.payload) begin
                errors++;
                $display("%0t: payload mismatch: expected %h, got %h", $time, exp.payload, pl);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                              aclk;
    logic                              aresetn;
    logic [brfr_pkg::ByteWidth-1:0]    s_tdata;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [brfr_pkg::OutDataWidth-1:0] m_tdata;
    logic                              m_tvalid;
    logic                              m_tready;
    logic                              cfg_we;
    brfr_pkg::cfg_idx_t                cfg_index;
    logic [brfr_pkg::CodeWidth-1:0]    cfg_data;

    reply_scoreboard sb;
    bit no_idle;
    bit hold_req;
    int cycle_count;

    boot_reply_frame_receiver_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[boot_reply_frame_receiver_unit] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_reply(m_tdata);
    end

    // result side: random stalls, plus one long hold on request
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_tready = no_idle || ($urandom_range(99) >= 34);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!no_idle && $urandom_range(99) < 34) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata = b;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b);
        @(negedge aclk);
    endtask

    // wait until every reply is in and the block has gone quiet
    task automatic settle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (5) @(negedge aclk);
    endtask

    task automatic write_code(input brfr_pkg::cfg_idx_t idx, input logic [3:0] v);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        @(posedge aclk);
        sb.write_code(idx, v);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic set_codes(input logic [3:0] boot, input logic [3:0] ack,
                             input logic [3:0] crc);
        write_code(brfr_pkg::CFG_BOOT_ENTERED, boot);
        write_code(brfr_pkg::CFG_ACK, ack);
        write_code(brfr_pkg::CFG_CRC_ERROR, crc);
    endtask

    task automatic send_frame(input logic [7:0] addr, input logic [7:0] type_byte,
                              input logic [15:0] payload, input bit bad_sum);
        brfr_pkg::kind_t k;
        logic [7:0]      sum;
        logic [7:0]      ck;
        k = sb.match_kind(type_byte[3:0]);
        sum = addr + type_byte;
        send_byte(addr);
        send_byte(type_byte);
        if (k != brfr_pkg::KIND_UNKNOWN) begin
            if (k == brfr_pkg::KIND_BOOT) begin
                send_byte(payload[15:8]);
                send_byte(payload[7:0]);
                sum = sum + payload[15:8] + payload[7:0];
            end else if (k == brfr_pkg::KIND_CRCERR) begin
                send_byte(payload[7:0]);
                sum = sum + payload[7:0];
            end
            ck = 8'd0 - sum;
            if (bad_sum) ck = ck + 8'($urandom_range(1, 255));
            send_byte(ck);
        end
    endtask

    task automatic random_frame();
        logic [7:0] addr;
        logic [3:0] seq;
        logic [3:0] t;
        int         r;
        r = $urandom_range(99);
        addr = 8'($urandom_range(255));
        seq = 4'($urandom_range(15));
        if (r < 8) begin
            send_byte(8'($urandom_range(255)));
        end else if (r < 18) begin
            do t = 4'($urandom_range(15));
            while (sb.match_kind(t) != brfr_pkg::KIND_UNKNOWN);
            send_frame(addr, {seq, t}, 16'd0, 1'b0);
        end else begin
            case ($urandom_range(2))
                0: t = sb.boot_code;
                1: t = sb.ack_code;
                default: t = sb.crc_code;
            endcase
            send_frame(addr, {seq, t}, 16'($urandom_range(65535)), $urandom_range(9) == 0);
        end
    endtask

    initial begin
        logic [3:0] code_tab [NUM_SETTINGS][3];
        logic [7:0] ck_sum;
        int         start;
        bit         hold_done;

        code_tab = '{'{4'd2, 4'd3, 4'd4}, '{4'd0, 4'd15, 4'd7}, '{4'd15, 4'd0, 4'd0},
                     '{4'd5, 4'd5, 4'd5}, '{4'd9, 4'd6, 4'd9}, '{4'd15, 4'd15, 4'd15}};
        sb = new();
        cycle_count = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        aresetn = 1'b0;
        s_tdata = '0;
        s_tvalid = 1'b0;
        cfg_we = 1'b0;
        cfg_index = brfr_pkg::CFG_BOOT_ENTERED;
        cfg_data = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // directed frames at the reset codes
        send_frame(8'h00, {4'h0, brfr_pkg::BOOT_CODE_RST}, 16'h0000, 1'b0);
        send_frame(8'hFF, {4'hF, brfr_pkg::BOOT_CODE_RST}, 16'hFFFF, 1'b0);
        send_frame(8'h5A, {4'h3, brfr_pkg::ACK_CODE_RST}, 16'h0000, 1'b0);
        send_frame(8'hA5, {4'h9, brfr_pkg::CRCERR_CODE_RST}, 16'h00C3, 1'b0);
        send_frame(8'h17, {4'h6, brfr_pkg::ACK_CODE_RST}, 16'h0000, 1'b1);
        send_frame(8'h80, {4'hC, 4'hE}, 16'h0000, 1'b0);

        // boot code changed mid-frame, type no longer matches
        send_byte(8'h11);
        send_byte({4'h5, brfr_pkg::BOOT_CODE_RST});
        settle();
        write_code(brfr_pkg::CFG_BOOT_ENTERED, 4'd9);
        send_byte(8'hAB);
        send_byte(8'hCD);
        ck_sum = 8'h11 + {4'h5, brfr_pkg::BOOT_CODE_RST} + 8'hAB + 8'hCD;
        send_byte(8'd0 - ck_sum);

        // crc error frame that turns into boot entered at the checksum
        send_byte(8'h22);
        send_byte({4'h7, brfr_pkg::CRCERR_CODE_RST});
        send_byte(8'h9C);
        settle();
        write_code(brfr_pkg::CFG_BOOT_ENTERED, brfr_pkg::CRCERR_CODE_RST);
        ck_sum = 8'h22 + {4'h7, brfr_pkg::CRCERR_CODE_RST} + 8'h9C;
        send_byte(8'd0 - ck_sum);

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            settle();
            set_codes(code_tab[p][0], code_tab[p][1], code_tab[p][2]);
            no_idle = (p == 1);
            start = sb.bytes_seen;
            while (sb.bytes_seen - start < PHASE_BYTES) begin
                if (p == 3 && !hold_done && sb.bytes_seen - start > 100) begin
                    hold_req = 1'b1;
                    hold_done = 1'b1;
                end
                random_frame();
            end
        end

        settle();
        repeat (8) @(negedge aclk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d replies never arrived", $time, sb.pending());
        end
        $display("sent %0d bytes, checked %0d replies", sb.bytes_seen, sb.replies_seen);
        $display("code settings: reset, %0d random phases, mid-frame code rewrites",
                 NUM_SETTINGS);
        if (sb.errors == 0) begin
            $display("[boot_reply_frame_receiver_unit] OK");
        end else begin
            $display("[boot_reply_frame_receiver_unit] ERROR");
        end
        $finish;
    end

endmodule
